[rtl/tqv_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqv_pkg
// Shared types and constants of the tiled quad vertex generator.
// ---------------------------------------------------------------------------
package tqv_pkg;

   localparam int MAX_TILES = 1024;
   localparam int CNT_W     = $clog2(MAX_TILES) + 1;   // holds MAX_TILES itself
   localparam int SPAN_STEPS = 17;                      // quotient bits of ceil division
   localparam int IDX_W     = 22;

   // register indexes
   localparam logic [2:0] REG_WORLD_W = 3'd0;
   localparam logic [2:0] REG_WORLD_H = 3'd1;
   localparam logic [2:0] REG_TILE_W  = 3'd2;
   localparam logic [2:0] REG_TILE_H  = 3'd3;
   localparam logic [2:0] REG_ORG_U   = 3'd4;
   localparam logic [2:0] REG_ORG_V   = 3'd5;
   localparam logic [2:0] REG_SIZE_U  = 3'd6;
   localparam logic [2:0] REG_SIZE_V  = 3'd7;

   localparam logic [1:0] CORNER_BR = 2'd3;

   typedef struct packed {
      logic [15:0] world_w;
      logic [15:0] world_h;
      logic [15:0] tile_w;
      logic [15:0] tile_h;
      logic [15:0] org_u;
      logic [15:0] org_v;
      logic [15:0] size_u;
      logic [15:0] size_v;
   } cfg_type;

   // tile counts of the mesh and recompute status
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] nx;
      logic [CNT_W-1:0] ny;
   } span_type;

   // one classified tile, ready for vertex emission
   typedef struct packed {
      logic             tvld;
      logic [15:0]      pxl;
      logic [15:0]      pxr;
      logic [15:0]      pyt;
      logic [15:0]      pyb;
      logic [15:0]      mu;     // scaled right-edge u
      logic [15:0]      mv;     // scaled bottom-edge v
      logic [IDX_W-1:0] base;
      logic [CNT_W:0]   nx2;
   } tile_type;

endpackage

[rtl/tiled_quad_vertex_generator.sv]
`timescale 1ns / 1ps
// An accepted tile passes front stages a, b and c, the tile queue and the back result register.
// Tiles are pipelined: a new tile can be accepted before the four vertex beats of
// the previous one are out, as long as the queue and the front stages have room.
// After a write to a world or tile size register the tile counts are recomputed,
// during which no tile is accepted.
// Reset is synchronous; registers return to their reset values, queues empty.
// ---------------------------------------------------------------------------
// tiled_quad_vertex_generator
// Emits the four corner vertices of a mesh tile with position, uv and index.
// ---------------------------------------------------------------------------
module tiled_quad_vertex_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // tile_col, tile_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // pos_x, pos_y, tex_u, tex_v, vertex_index, corner, tile_valid
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   tqv_pkg::cfg_type  cfg_ff;
   tqv_pkg::span_type span;
   tqv_pkg::tile_type push_data, head;
   logic push, push_ready, pop, head_valid, span_start;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.world_w <= 16'd16;
         cfg_ff.world_h <= 16'd16;
         cfg_ff.tile_w  <= 16'd16;
         cfg_ff.tile_h  <= 16'd16;
         cfg_ff.org_u   <= 16'd0;
         cfg_ff.org_v   <= 16'd0;
         cfg_ff.size_u  <= 16'd32768;
         cfg_ff.size_v  <= 16'd32768;
      end else if (csr_we) begin
         case (csr_addr)
            tqv_pkg::REG_WORLD_W: cfg_ff.world_w <= csr_wdata;
            tqv_pkg::REG_WORLD_H: cfg_ff.world_h <= csr_wdata;
            tqv_pkg::REG_TILE_W:  cfg_ff.tile_w  <= csr_wdata;
            tqv_pkg::REG_TILE_H:  cfg_ff.tile_h  <= csr_wdata;
            tqv_pkg::REG_ORG_U:   cfg_ff.org_u   <= csr_wdata;
            tqv_pkg::REG_ORG_V:   cfg_ff.org_v   <= csr_wdata;
            tqv_pkg::REG_SIZE_U:  cfg_ff.size_u  <= csr_wdata;
            tqv_pkg::REG_SIZE_V:  cfg_ff.size_v  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tile counts follow any write to the world or tile size
   assign span_start = csr_we & (csr_addr == tqv_pkg::REG_WORLD_W |
                                 csr_addr == tqv_pkg::REG_WORLD_H |
                                 csr_addr == tqv_pkg::REG_TILE_W  |
                                 csr_addr == tqv_pkg::REG_TILE_H);

   tqv_span_div u_span (
      .clock (clock), .reset (reset), .start (span_start), .cfg (cfg_ff), .span (span)
   );

   tqv_front u_front (
      .clock (clock), .reset (reset), .cfg (cfg_ff), .span (span),
      .in_valid (req_tvalid), .in_ready (req_tready),
      .in_col (req_tdata[9:0]), .in_row (req_tdata[19:10]),
      .push (push), .push_ready (push_ready), .push_data (push_data)
   );

   tqv_fifo u_fifo (
      .clock (clock), .reset (reset), .push (push), .push_ready (push_ready),
      .push_data (push_data), .pop (pop), .head_valid (head_valid), .head (head)
   );

   tqv_back u_back (
      .clock (clock), .reset (reset), .cfg (cfg_ff), .head_valid (head_valid),
      .head (head), .pop (pop), .out_valid (rsp_tvalid), .out_ready (rsp_tready),
      .out_data (rsp_tdata), .out_last (rsp_tlast)
   );

   // no tile enters while the tile counts are being recomputed
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      span.busy |-> !req_tready) else $error("tile accepted during count update");

   // last beat of a tile is exactly the bottom-right corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[87:86] == tqv_pkg::CORNER_BR)))
      else $error("tlast does not match corner");

   // a tile outside the mesh carries a zero payload
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[88] |-> rsp_tdata[85:0] == 86'd0)
      else $error("outside tile with nonzero payload");

endmodule

[rtl/tqv_span_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqv_span_div
// Serial ceiling divider that derives the tile counts per axis.
// ---------------------------------------------------------------------------
module tqv_span_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tqv_pkg::cfg_type   cfg,
   output tqv_pkg::span_type  span
);

   logic        start_ff;
   logic        run_ff, run_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] nw_ff, nw_in, nh_ff, nh_in;
   logic [15:0] dw_ff, dw_in, dh_ff, dh_in;
   logic [15:0] rw_ff, rw_in, rh_ff, rh_in;
   logic [16:0] qw_ff, qw_in, qh_ff, qh_in;
   logic [tqv_pkg::CNT_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [15:0] tw1, th1;
   logic [16:0] tx, ty;
   logic        gx, gy;

   // operand setup and one quotient bit per axis a cycle
   always_comb begin
      tw1 = (cfg.tile_w == 16'd0) ? 16'd1 : cfg.tile_w;
      th1 = (cfg.tile_h == 16'd0) ? 16'd1 : cfg.tile_h;
      tx  = {rw_ff, nw_ff[16]};
      ty  = {rh_ff, nh_ff[16]};
      gx  = tx >= {1'b0, dw_ff};
      gy  = ty >= {1'b0, dh_ff};
      run_in = run_ff;
      cnt_in = cnt_ff;
      nw_in = nw_ff; nh_in = nh_ff; dw_in = dw_ff; dh_in = dh_ff;
      rw_in = rw_ff; rh_in = rh_ff; qw_in = qw_ff; qh_in = qh_ff;
      nx_in = nx_ff; ny_in = ny_ff;
      if (start_ff) begin
         run_in = 1'b1;
         cnt_in = 5'd0;
         nw_in  = {1'b0, cfg.world_w} + {1'b0, tw1} - 17'd1;
         nh_in  = {1'b0, cfg.world_h} + {1'b0, th1} - 17'd1;
         dw_in  = tw1;
         dh_in  = th1;
         rw_in  = 16'd0;
         rh_in  = 16'd0;
         qw_in  = 17'd0;
         qh_in  = 17'd0;
      end else if (run_ff) begin
         nw_in = {nw_ff[15:0], 1'b0};
         nh_in = {nh_ff[15:0], 1'b0};
         rw_in = gx ? 16'(tx - {1'b0, dw_ff}) : tx[15:0];
         rh_in = gy ? 16'(ty - {1'b0, dh_ff}) : ty[15:0];
         qw_in = {qw_ff[15:0], gx};
         qh_in = {qh_ff[15:0], gy};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(tqv_pkg::SPAN_STEPS - 1)) begin
            run_in = 1'b0;
            nx_in = ({qw_ff[15:0], gx} > 17'(tqv_pkg::MAX_TILES)) ?
                    tqv_pkg::CNT_W'(tqv_pkg::MAX_TILES) : qw_in[tqv_pkg::CNT_W-1:0];
            ny_in = ({qh_ff[15:0], gy} > 17'(tqv_pkg::MAX_TILES)) ?
                    tqv_pkg::CNT_W'(tqv_pkg::MAX_TILES) : qh_in[tqv_pkg::CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         run_ff   <= 1'b0;
         cnt_ff   <= 5'd0;
         nx_ff    <= tqv_pkg::CNT_W'(1);
         ny_ff    <= tqv_pkg::CNT_W'(1);
      end else begin
         start_ff <= start;
         run_ff   <= run_in;
         cnt_ff   <= cnt_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
      end
      nw_ff <= nw_in; nh_ff <= nh_in; dw_ff <= dw_in; dh_ff <= dh_in;
      rw_ff <= rw_in; rh_ff <= rh_in; qw_ff <= qw_in; qh_ff <= qh_in;
   end

   assign span.busy = start_ff | run_ff;
   assign span.nx   = nx_ff;
   assign span.ny   = ny_ff;

endmodule

[rtl/tqv_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqv_front
// Accepts tiles, clips them at the world edge and divides out the texture
// fractions, four quotient bits a cycle.
// ---------------------------------------------------------------------------
module tqv_front (
   input  logic               clock,
   input  logic               reset,
   input  tqv_pkg::cfg_type   cfg,
   input  tqv_pkg::span_type  span,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [9:0]         in_col,
   input  logic [9:0]         in_row,
   output logic               push,
   input  logic               push_ready,
   output tqv_pkg::tile_type  push_data
);

   logic [15:0] tw1, th1, hx, hy;

   // stage a: corner products
   logic        a_vld_ff, a_vld_in, a_move;
   logic [9:0]  a_col_ff;
   logic [25:0] a_xt0_ff, a_xt1_ff, a_yt0_ff, a_yt1_ff;
   logic [20:0] a_rownx_ff;

   // stage b: clip and divide
   logic        b_vld_ff, b_vld_in, b_move, b_last;
   logic [1:0]  b_cnt_ff, b_cnt_in;
   logic [15:0] b_ru_ff, b_ru_in, b_rv_ff, b_rv_in;
   logic [15:0] b_qu_ff, b_qu_in, b_qv_ff, b_qv_in;
   logic        b_clipx_ff, b_clipx_in, b_clipy_ff, b_clipy_in;
   tqv_pkg::tile_type b_ent_ff, b_ent_in;
   logic [15:0] ru_nx, rv_nx, qu_nx, qv_nx;
   logic [16:0] tu, tv;
   logic [15:0] xr, ybt;

   // stage c: fractions, scaled on the way into the queue
   logic        c_vld_ff, c_vld_in, c_move;
   logic [15:0] c_fu_ff, c_fv_ff;
   tqv_pkg::tile_type c_ent_ff;
   logic [31:0] pu, pv;

   assign tw1 = (cfg.tile_w == 16'd0) ? 16'd1 : cfg.tile_w;
   assign th1 = (cfg.tile_h == 16'd0) ? 16'd1 : cfg.tile_h;
   assign hx  = 16'(({1'b0, cfg.world_w} + 17'd1) >> 1);
   assign hy  = cfg.world_h >> 1;

   // handshakes between stages
   assign c_move   = c_vld_ff & push_ready;
   assign b_last   = b_cnt_ff == 2'd3;
   assign b_move   = b_vld_ff & b_last & (~c_vld_ff | c_move);
   assign a_move   = a_vld_ff & (~b_vld_ff | b_move);
   assign in_ready = ~span.busy & (~a_vld_ff | a_move);
   assign a_vld_in = (in_valid & in_ready) | (a_vld_ff & ~a_move);
   assign c_vld_in = b_move | (c_vld_ff & ~c_move);

   // stage a registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
      if (in_valid & in_ready) begin
         a_col_ff   <= in_col;
         a_xt0_ff   <= 26'(in_col * tw1);
         a_xt1_ff   <= 26'(({1'b0, in_col} + 11'd1) * tw1);
         a_yt0_ff   <= 26'(in_row * th1);
         a_yt1_ff   <= 26'(({1'b0, in_row} + 11'd1) * th1);
         a_rownx_ff <= 21'(in_row * span.nx);
      end
   end

   // four restoring steps a cycle on both fractions
   always_comb begin
      ru_nx = b_ru_ff; rv_nx = b_rv_ff; qu_nx = b_qu_ff; qv_nx = b_qv_ff;
      tu = 17'd0; tv = 17'd0;
      for (int i = 0; i < 4; i++) begin
         tu = {ru_nx, 1'b0};
         tv = {rv_nx, 1'b0};
         if (tu >= {1'b0, tw1}) begin
            ru_nx = 16'(tu - {1'b0, tw1});
            qu_nx = {qu_nx[14:0], 1'b1};
         end else begin
            ru_nx = tu[15:0];
            qu_nx = {qu_nx[14:0], 1'b0};
         end
         if (tv >= {1'b0, th1}) begin
            rv_nx = 16'(tv - {1'b0, th1});
            qv_nx = {qv_nx[14:0], 1'b1};
         end else begin
            rv_nx = tv[15:0];
            qv_nx = {qv_nx[14:0], 1'b0};
         end
      end
   end

   // stage b next state: load a new tile, hand the finished one on, or keep dividing
   always_comb begin
      b_vld_in = b_vld_ff; b_cnt_in = b_cnt_ff;
      b_ru_in = b_ru_ff; b_rv_in = b_rv_ff; b_qu_in = b_qu_ff; b_qv_in = b_qv_ff;
      b_clipx_in = b_clipx_ff; b_clipy_in = b_clipy_ff; b_ent_in = b_ent_ff;
      xr  = (a_xt1_ff > {10'd0, cfg.world_w}) ? cfg.world_w : a_xt1_ff[15:0];
      ybt = (a_yt1_ff > {10'd0, cfg.world_h}) ? cfg.world_h : a_yt1_ff[15:0];
      if (a_move) begin
         b_vld_in   = 1'b1;
         b_cnt_in   = 2'd0;
         b_clipx_in = a_xt1_ff > {10'd0, cfg.world_w};
         b_clipy_in = a_yt1_ff > {10'd0, cfg.world_h};
         b_ru_in    = b_clipx_in ? 16'(cfg.world_w - a_xt0_ff[15:0]) : 16'd0;
         b_rv_in    = b_clipy_in ? 16'(a_yt1_ff[15:0] - cfg.world_h) : 16'd0;
         b_qu_in    = 16'd0;
         b_qv_in    = 16'd0;
         b_ent_in.tvld = (a_xt0_ff < {10'd0, cfg.world_w}) &
                         (a_yt0_ff < {10'd0, cfg.world_h});
         b_ent_in.pxl  = 16'(a_xt0_ff[15:0] - hx);
         b_ent_in.pxr  = 16'(xr - hx);
         b_ent_in.pyt  = 16'(hy - a_yt0_ff[15:0]);
         b_ent_in.pyb  = 16'(hy - ybt);
         b_ent_in.mu   = 16'd0;
         b_ent_in.mv   = 16'd0;
         b_ent_in.base = tqv_pkg::IDX_W'({a_rownx_ff, 2'b00} + {12'd0, a_col_ff, 1'b0});
         b_ent_in.nx2  = {span.nx, 1'b0};
      end else if (b_move) begin
         b_vld_in = 1'b0;
      end else if (b_vld_ff & ~b_last) begin
         b_cnt_in = b_cnt_ff + 2'd1;
         b_ru_in = ru_nx; b_rv_in = rv_nx; b_qu_in = qu_nx; b_qv_in = qv_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         b_cnt_ff <= 2'd0;
         c_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
         b_cnt_ff <= b_cnt_in;
         c_vld_ff <= c_vld_in;
      end
      b_ru_ff <= b_ru_in; b_rv_ff <= b_rv_in; b_qu_ff <= b_qu_in; b_qv_ff <= b_qv_in;
      b_clipx_ff <= b_clipx_in; b_clipy_ff <= b_clipy_in; b_ent_ff <= b_ent_in;
      // right u is the kept share, bottom v the clipped share
      if (b_move) begin
         c_fu_ff  <= b_clipx_ff ? {1'b0, qu_nx[15:1]} : 16'd32768;
         c_fv_ff  <= b_clipy_ff ? {1'b0, qv_nx[15:1]} : 16'd0;
         c_ent_ff <= b_ent_ff;
      end
   end

   // scale fractions into the texture rectangle
   assign pu = c_fu_ff * cfg.size_u;
   assign pv = c_fv_ff * cfg.size_v;

   always_comb begin
      push_data    = c_ent_ff;
      push_data.mu = pu[30:15];
      push_data.mv = pv[30:15];
   end

   assign push = c_move;

endmodule

[rtl/tqv_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqv_fifo
// Two-entry queue of classified tiles between front and back.
// ---------------------------------------------------------------------------
module tqv_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               push_ready,
   input  tqv_pkg::tile_type  push_data,
   input  logic               pop,
   output logic               head_valid,
   output tqv_pkg::tile_type  head
);

   tqv_pkg::tile_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign push_ready = cnt_ff != 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head       = mem_ff[rp_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

[rtl/tqv_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqv_back
// Walks the four corners of the head tile and drives the result register.
// ---------------------------------------------------------------------------
module tqv_back (
   input  logic               clock,
   input  logic               reset,
   input  tqv_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  tqv_pkg::tile_type  head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [95:0]        out_data,
   output logic               out_last
);

   logic        o_vld_ff;
   logic [1:0]  corner_ff;
   logic [15:0] px_ff, py_ff, tu_ff, tv_ff;
   logic [21:0] idx_ff;
   logic [1:0]  oc_ff;
   logic        otv_ff;
   logic        load;
   logic        xb, yb;
   logic [16:0] su, sv;
   logic [21:0] idx;

   assign load = head_valid & (~o_vld_ff | out_ready);
   assign pop  = load & (corner_ff == tqv_pkg::CORNER_BR);
   assign xb   = corner_ff[0];
   assign yb   = corner_ff[1];

   // corner selection, texture offset with saturation, buffer index
   always_comb begin
      su  = {1'b0, xb ? head.mu : 16'd0} + {1'b0, cfg.org_u};
      sv  = {1'b0, yb ? head.mv : cfg.size_v} + {1'b0, cfg.org_v};
      idx = tqv_pkg::IDX_W'(head.base + (yb ? 22'(head.nx2) : 22'd0) + 22'(xb));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff  <= 1'b0;
         corner_ff <= 2'd0;
      end else begin
         if (load) begin
            o_vld_ff  <= 1'b1;
            corner_ff <= corner_ff + 2'd1;
         end else if (out_ready) begin
            o_vld_ff <= 1'b0;
         end
      end
      if (load) begin
         oc_ff  <= corner_ff;
         otv_ff <= head.tvld;
         if (head.tvld) begin
            px_ff  <= xb ? head.pxr : head.pxl;
            py_ff  <= yb ? head.pyb : head.pyt;
            tu_ff  <= su[16] ? 16'hFFFF : su[15:0];
            tv_ff  <= sv[16] ? 16'hFFFF : sv[15:0];
            idx_ff <= idx;
         end else begin
            px_ff <= 16'd0; py_ff <= 16'd0; tu_ff <= 16'd0; tv_ff <= 16'd0;
            idx_ff <= 22'd0;
         end
      end
   end

   assign out_valid = o_vld_ff;
   assign out_data  = {7'd0, otv_ff, oc_ff, idx_ff, tv_ff, tu_ff, py_ff, px_ff};
   assign out_last  = oc_ff == tqv_pkg::CORNER_BR;

endmodule

[test/tiled_quad_vertex_generator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiled_quad_vertex_generator_tb
// Drives tiles through the quad vertex generator under several mesh and
// texture settings. Each accepted tile queues four predicted vertex beats.
// Every vertex beat is checked field by field against the oldest one.
// ---------------------------------------------------------------------------
module tiled_quad_vertex_generator_tb;

   typedef struct {
      logic [95:0] data;
      logic        last;
   } vertex_beat_type;

   // vertex prediction and expected-beat store
   class vertex_scoreboard;
      logic [15:0]  world_w = 16, world_h = 16, tile_w = 16, tile_h = 16;
      logic [15:0]  org_u = 0, org_v = 0, size_u = 32768, size_v = 32768;
      vertex_beat_type pending_vertices[$];
      int           mismatches = 0;
      int           vertices_seen = 0;
      int           valid_vertices = 0;

      function void set_reg(logic [2:0] addr, logic [15:0] val);
         case (addr)
            tqv_pkg::REG_WORLD_W: world_w = val;
            tqv_pkg::REG_WORLD_H: world_h = val;
            tqv_pkg::REG_TILE_W:  tile_w  = val;
            tqv_pkg::REG_TILE_H:  tile_h  = val;
            tqv_pkg::REG_ORG_U:   org_u   = val;
            tqv_pkg::REG_ORG_V:   org_v   = val;
            tqv_pkg::REG_SIZE_U:  size_u  = val;
            tqv_pkg::REG_SIZE_V:  size_v  = val;
            default: ;
         endcase
      endfunction

      function longint unsigned tile_count(longint unsigned span, longint unsigned tsz);
         longint unsigned n;
         n = (span + tsz - 1) / tsz;
         return (n > tqv_pkg::MAX_TILES) ? tqv_pkg::MAX_TILES : n;
      endfunction

      function logic [15:0] scale_tex(longint unsigned frac, longint unsigned sz,
                                      longint unsigned org);
         longint unsigned t;
         t = ((frac * sz) >> 15) + org;
         return (t > 65535) ? 16'hFFFF : t[15:0];
      endfunction

      // floor((a - b) / 2) in 16-bit two's complement
      function logic [15:0] centred(longint unsigned a, longint unsigned b);
         longint d;
         d = longint'(a) - longint'(b);
         d = d >>> 1;
         return d[15:0];
      endfunction

      // queue the four corner beats of one accepted tile
      function void note_tile(logic [9:0] col, logic [9:0] row);
         longint unsigned tw, th, nx, ny, xt, yt, xc, yc, fu, fv, idx;
         logic            in_mesh;
         vertex_beat_type b;
         tw = (tile_w == 0) ? 1 : tile_w;
         th = (tile_h == 0) ? 1 : tile_h;
         nx = tile_count(world_w, tw);
         ny = tile_count(world_h, th);
         in_mesh = (col < nx) && (row < ny);
         for (int k = 0; k < 4; k++) begin
            b.data = '0;
            b.data[87:86] = k[1:0];
            b.last = (k == 3);
            if (in_mesh) begin
               xt = (longint'(col) + k[0]) * tw;
               yt = (longint'(row) + k[1]) * th;
               xc = (xt < world_w) ? xt : world_w;
               yc = (yt < world_h) ? yt : world_h;
               fu = k[0] ? (((tw - (xt - xc)) << 15) / tw) : 0;
               fv = k[1] ? (((yt - yc) << 15) / th) : 32768;
               idx = longint'(row) * 4 * nx + k[1] * 2 * nx + longint'(col) * 2 + k[0];
               b.data[15:0]  = centred(2 * xc, world_w);
               b.data[31:16] = centred(world_h, 2 * yc);
               b.data[47:32] = scale_tex(fu, size_u, org_u);
               b.data[63:48] = scale_tex(fv, size_v, org_v);
               b.data[85:64] = idx[21:0];
               b.data[88]    = 1'b1;
            end
            pending_vertices.push_back(b);
         end
      endfunction

      function void check_vertex(logic [95:0] got, logic got_last);
         vertex_beat_type w;
         vertices_seen++;
         if (got[88]) valid_vertices++;
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected vertex beat data=%h last=%b", got, got_last);
            return;
         end
         w = pending_vertices.pop_front();
         if (got[15:0] !== w.data[15:0] || got[31:16] !== w.data[31:16] ||
             got[47:32] !== w.data[47:32] || got[63:48] !== w.data[63:48] ||
             got[85:64] !== w.data[85:64] || got[87:86] !== w.data[87:86] ||
             got[88] !== w.data[88] || got_last !== w.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("vertex mismatch corner exp %0d got %0d", w.data[87:86], got[87:86]);
               $display("  pos_x exp %h got %h  pos_y exp %h got %h",
                        w.data[15:0], got[15:0], w.data[31:16], got[31:16]);
               $display("  tex_u exp %h got %h  tex_v exp %h got %h",
                        w.data[47:32], got[47:32], w.data[63:48], got[63:48]);
               $display("  index exp %h got %h  valid exp %b got %b  last exp %b got %b",
                        w.data[85:64], got[85:64], w.data[88], got[88], w.last, got_last);
            end
         end
      endfunction

      function int pending();
         return pending_vertices.size();
      endfunction
   endclass

   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;     // tile_col, tile_row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // pos_x, pos_y, tex_u, tex_v, vertex_index, corner, tile_valid
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   vertex_scoreboard vsb = new();
   bit  steady_flow = 0;
   int  tiles_sent = 0;
   int  setting_count = 0;
   int  quiet_cycles = 0;

   tiled_quad_vertex_generator i_dut (.*);

   always #1 clock = ~clock;

   function automatic bit take_gap();
      return !steady_flow && ($urandom_range(99) < 25);
   endfunction

   // result side: check beats, random backpressure, stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) vsb.check_vertex(rsp_tdata, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
      rsp_tready <= !take_gap();
   end

   task automatic send_tile(logic [9:0] col, logic [9:0] row);
      if (take_gap()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (take_gap());
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, row, col};
      do @(posedge clock); while (!req_tready);
      vsb.note_tile(col, row);
      tiles_sent++;
   endtask

   // drain, let the pipeline settle, then write all registers
   task automatic load_setting(logic [15:0] ww, logic [15:0] wh, logic [15:0] tw,
                               logic [15:0] th, logic [15:0] ou, logic [15:0] ov,
                               logic [15:0] su, logic [15:0] sv);
      logic [15:0] vals [8];
      vals = '{ww, wh, tw, th, ou, ov, su, sv};
      req_tvalid <= 1'b0;
      while (vsb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         vsb.set_reg(i[2:0], vals[i]);
      end
      csr_we <= 1'b0;
      setting_count++;
   endtask

   // random tile mostly near the mesh, sometimes anywhere
   task automatic send_random_tile(int nx, int ny);
      logic [9:0] col, row;
      if ($urandom_range(99) < 15) begin
         col = 10'($urandom_range(1023));
         row = 10'($urandom_range(1023));
      end else begin
         col = 10'($urandom_range(nx));
         row = 10'($urandom_range(ny));
      end
      send_tile(col, row);
   endtask

   initial begin
      int          n, m;
      logic [15:0] ww, wh, tw, th;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: one tile mesh
      send_tile(10'd0, 10'd0);
      send_tile(10'd1, 10'd0);
      send_tile(10'd0, 10'd1);
      send_tile(10'd1023, 10'd1023);

      // full-range world of unit tiles: capped counts, top of the index range, saturation
      load_setting(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd32768, 16'd32768,
                   16'd32768, 16'd32768);
      send_tile(10'd1023, 10'd1023);
      send_tile(10'd1023, 10'd0);
      send_tile(10'd512, 10'd700);
      send_tile(10'd0, 10'd0);

      // zero tile size behaves as one
      load_setting(16'd5, 16'd3, 16'd0, 16'd0, 16'd100, 16'd200, 16'd1000, 16'd2000);
      send_tile(10'd4, 10'd2);
      send_tile(10'd5, 10'd0);
      send_tile(10'd0, 10'd0);

      // empty world: every tile outside
      load_setting(16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd0, 16'd32768, 16'd32768);
      send_tile(10'd0, 10'd0);
      send_tile(10'd3, 10'd3);

      // clipped edge tiles, zero texture size
      load_setting(16'd100, 16'd70, 16'd30, 16'd40, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tile(10'd3, 10'd1);
      send_tile(10'd2, 10'd0);
      send_tile(10'd0, 10'd0);
      send_tile(10'd4, 10'd0);
      send_tile(10'd0, 10'd2);

      // tile larger than the world, full rectangle with odd sizes
      load_setting(16'd33, 16'd17, 16'hFFFF, 16'hFFFF, 16'd1, 16'd32767,
                   16'd32767, 16'd1);
      send_tile(10'd0, 10'd0);
      send_tile(10'd1, 10'd0);

      // random settings with small meshes
      for (int p = 0; p < 8; p++) begin
         n  = $urandom_range(1, 8);
         m  = $urandom_range(1, 8);
         ww = 16'($urandom_range(1, 65535));
         wh = 16'($urandom_range(1, 65535));
         tw = 16'(ww / n + $urandom_range(0, 15));
         th = 16'(wh / m + $urandom_range(0, 15));
         if (tw == 0) tw = 1;
         if (th == 0) th = 1;
         load_setting(ww, wh, tw, th, 16'($urandom_range(0, 32768)),
                      16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                      16'($urandom_range(0, 32768)));
         steady_flow = (p == 3);
         repeat (18) send_random_tile(n, m);
         steady_flow = 0;
      end

      req_tvalid <= 1'b0;
      while (vsb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("%0d tiles under %0d register settings, %0d vertex beats (%0d inside mesh)",
               tiles_sent, setting_count, vsb.vertices_seen, vsb.valid_vertices);
      $display("mismatches: %0d", vsb.mismatches);
      if (vsb.mismatches == 0 && vsb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
